// ===== rtl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Field widths and the status bundle shared by the scan unit and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

    localparam int PAGE_W = 16;
    localparam int CFG_W  = 5;
    localparam int FIDX_W = 4;
    localparam int CNT_W  = 32;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic hit;
        logic empty;
    } t_scan_flags;

endpackage

`default_nettype wire

// ===== rtl/lrupr_scan.sv =====
// ----------------------------------------------------------------------------
// LRU scan unit
// One comparator pass per frame: finds the hit, the first empty and the oldest.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_scan #(
    parameter int FRAMES = 16,
    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic                         i_step,
    input  wire logic [IW-1:0]                i_idx,
    input  wire logic [lrupr_pkg::PAGE_W-1:0] i_page,
    input  wire logic [lrupr_pkg::PAGE_W-1:0] i_entry_page,
    input  wire logic                         i_entry_valid,
    input  wire logic [IW-1:0]                i_entry_rank,
    output lrupr_pkg::t_scan_flags            o_flags,
    output logic [IW-1:0]                     o_hit_idx,
    output logic [IW-1:0]                     o_hit_rank,
    output logic [IW-1:0]                     o_empty_idx,
    output logic [IW-1:0]                     o_old_idx,
    output logic [lrupr_pkg::PAGE_W-1:0]      o_old_page
);

    lrupr_pkg::t_scan_flags          r_flags;
    logic [IW-1:0]                   r_hit_idx;
    logic [IW-1:0]                   r_hit_rank;
    logic [IW-1:0]                   r_empty_idx;
    logic [IW-1:0]                   r_old_idx;
    logic [IW-1:0]                   r_old_rank;
    logic [lrupr_pkg::PAGE_W-1:0]    r_old_page;

    logic match;
    logic older;

    assign match = i_entry_valid && (i_entry_page == i_page);
    assign older = (i_idx == '0) || (i_entry_rank > r_old_rank);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_start) begin
            r_flags <= '0;
        end else if (i_step) begin
            if (match && !r_flags.hit) begin
                r_flags.hit <= 1'b1;
            end
            if (!i_entry_valid && !r_flags.empty) begin
                r_flags.empty <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (match && !r_flags.hit) begin
                r_hit_idx  <= i_idx;
                r_hit_rank <= i_entry_rank;
            end
            if (!i_entry_valid && !r_flags.empty) begin
                r_empty_idx <= i_idx;
            end
            if (older) begin
                r_old_idx  <= i_idx;
                r_old_rank <= i_entry_rank;
                r_old_page <= i_entry_page;
            end
        end
    end

    assign o_flags     = r_flags;
    assign o_hit_idx   = r_hit_idx;
    assign o_hit_rank  = r_hit_rank;
    assign o_empty_idx = r_empty_idx;
    assign o_old_idx   = r_old_idx;
    assign o_old_page  = r_old_page;

endmodule

`default_nettype wire

// ===== rtl/lru_page_replacement_top.sv =====
// Sequence: a scan of the n active frames, n = active frames, one frame per cycle
// through the single read port of the page memory, then a drain step, the update step
// and a return to idle; a new page reference is taken only in idle.
// A result held by the receiver holds the update step and the input with it.
// Reset: synchronous, active low; all frames empty, ranks and fault count zero,
// frames_in_use set to 16. Page memory contents are not cleared.
// ----------------------------------------------------------------------------
// LRU page replacement top level
// Frame table, page memory, sequencer and result register around the scan unit.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_top #(
    parameter int FRAMES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_frames_in_use_we,
    input  wire logic [lrupr_pkg::CFG_W-1:0]   i_frames_in_use,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [lrupr_pkg::PAGE_W-1:0]  i_page_number,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic                               o_was_hit,
    output logic [lrupr_pkg::FIDX_W-1:0]       o_frame_index,
    output logic                               o_did_evict,
    output logic [lrupr_pkg::PAGE_W-1:0]       o_evicted_page,
    output logic [lrupr_pkg::CNT_W-1:0]        o_fault_total
);

    localparam int IW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW  = (IW + 1 > lrupr_pkg::CFG_W) ? IW + 1 : lrupr_pkg::CFG_W;
    localparam int FIW = (IW > lrupr_pkg::FIDX_W) ? IW : lrupr_pkg::FIDX_W;
    localparam logic [CW-1:0] FRAMES_C  = CW'(FRAMES);
    localparam logic [IW:0]   RANK_NEW  = (IW + 1)'(FRAMES);
    localparam logic [IW-1:0] RANK_MAX  = IW'(FRAMES - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_LAST   = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [lrupr_pkg::CFG_W-1:0]     r_cfg;
    logic [IW-1:0]                   r_n_m1;
    logic [IW-1:0]                   r_idx;
    logic                            r_step;
    logic [IW-1:0]                   r_step_idx;
    logic [lrupr_pkg::PAGE_W-1:0]    r_page;
    logic [lrupr_pkg::PAGE_W-1:0]    r_rd_page;
    logic [lrupr_pkg::PAGE_W-1:0]    r_mem [FRAMES];
    logic [FRAMES-1:0]               r_valid, n_valid;
    logic [IW-1:0]                   r_rank [FRAMES];
    logic [IW-1:0]                   n_rank [FRAMES];
    logic [lrupr_pkg::CNT_W-1:0]     r_fault, n_fault;
    logic                            r_out_vld;
    logic                            r_was_hit;
    logic [lrupr_pkg::FIDX_W-1:0]    r_frame_index;
    logic                            r_did_evict;
    logic [lrupr_pkg::PAGE_W-1:0]    r_evicted_page;

    lrupr_pkg::t_scan_flags          scan_flags;
    logic [IW-1:0]                   hit_idx;
    logic [IW-1:0]                   hit_rank;
    logic [IW-1:0]                   empty_idx;
    logic [IW-1:0]                   old_idx;
    logic [lrupr_pkg::PAGE_W-1:0]    old_page;

    logic                            in_acc;
    logic                            out_free;
    logic                            upd_fire;
    logic [CW-1:0]                   cfg_ext;
    logic [CW-1:0]                   n_cnt;
    logic [IW-1:0]                   sel_idx;
    logic [IW:0]                     old_rank;
    logic                            evict;
    logic [FIW-1:0]                  sel_ext;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_vld || !i_stall;
    assign upd_fire = (r_state == ST_UPDATE) && out_free;

    assign cfg_ext = CW'(r_cfg);
    always_comb begin
        if (cfg_ext == '0) begin
            n_cnt = CW'(1);
        end else if (cfg_ext > FRAMES_C) begin
            n_cnt = FRAMES_C;
        end else begin
            n_cnt = cfg_ext;
        end
    end

    lrupr_scan #(
        .FRAMES(FRAMES)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_acc),
        .i_step       (r_step),
        .i_idx        (r_step_idx),
        .i_page       (r_page),
        .i_entry_page (r_rd_page),
        .i_entry_valid(r_valid[r_step_idx]),
        .i_entry_rank (r_rank[r_step_idx]),
        .o_flags      (scan_flags),
        .o_hit_idx    (hit_idx),
        .o_hit_rank   (hit_rank),
        .o_empty_idx  (empty_idx),
        .o_old_idx    (old_idx),
        .o_old_page   (old_page)
    );

    always_comb begin
        if (scan_flags.hit) begin
            sel_idx  = hit_idx;
            old_rank = {1'b0, hit_rank};
        end else if (scan_flags.empty) begin
            sel_idx  = empty_idx;
            old_rank = RANK_NEW;
        end else begin
            sel_idx  = old_idx;
            old_rank = RANK_NEW;
        end
    end

    assign evict   = !scan_flags.hit && !scan_flags.empty;
    assign sel_ext = FIW'(sel_idx);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_n_m1) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_frames_in_use_we) begin
            n_valid = '0;
            for (int k = 0; k < FRAMES; k++) begin
                n_rank[k] = '0;
            end
        end else if (upd_fire) begin
            for (int k = 0; k < FRAMES; k++) begin
                if (IW'(k) != sel_idx && IW'(k) <= r_n_m1 && r_valid[k] &&
                    {1'b0, r_rank[k]} < old_rank && r_rank[k] != RANK_MAX) begin
                    n_rank[k] = r_rank[k] + 1'b1;
                end
            end
            n_rank[sel_idx]  = '0;
            n_valid[sel_idx] = 1'b1;
        end
    end

    always_comb begin
        n_fault = r_fault;
        if (!scan_flags.hit && r_fault != '1) begin
            n_fault = r_fault + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg     <= lrupr_pkg::CFG_RESET;
            r_valid   <= '0;
            r_fault   <= '0;
            r_out_vld <= 1'b0;
            r_step    <= 1'b0;
            for (int k = 0; k < FRAMES; k++) begin
                r_rank[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_rank  <= n_rank;
            r_step  <= (r_state == ST_SCAN);
            if (i_frames_in_use_we) begin
                r_cfg <= i_frames_in_use;
            end
            if (upd_fire) begin
                r_fault   <= n_fault;
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_page <= i_page_number;
            r_n_m1 <= IW'(n_cnt - CW'(1));
            r_idx  <= '0;
        end else if (r_state == ST_SCAN && r_idx != r_n_m1) begin
            r_idx <= r_idx + 1'b1;
        end
        r_step_idx <= r_idx;
        r_rd_page  <= r_mem[r_idx];
        if (upd_fire && !scan_flags.hit) begin
            r_mem[sel_idx] <= r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_was_hit      <= scan_flags.hit;
            r_frame_index  <= sel_ext[lrupr_pkg::FIDX_W-1:0];
            r_did_evict    <= evict;
            r_evicted_page <= evict ? old_page : '0;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_was_hit      = r_was_hit;
    assign o_frame_index  = r_frame_index;
    assign o_did_evict    = r_did_evict;
    assign o_evicted_page = r_evicted_page;
    assign o_fault_total  = r_fault;

`ifndef SYNTHESIS
    a_load_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_UPDATE))
        else $error("result loaded outside the update step");

    a_fault_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_fault != $past(r_fault)) |->
            (r_fault == $past(r_fault) + 1'b1))
        else $error("fault count moved by other than one");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_hit |-> !o_did_evict && (o_evicted_page == '0))
        else $error("hit reported an eviction");

    a_busy_no_config_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) && $past(r_state == ST_LAST) |-> $stable(r_n_m1))
        else $error("active frame count changed during a scan");
`endif

endmodule

`default_nettype wire
